// ===== rtl/vf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vf_pkg
// Shared types and constants of the three-element fixed-point vector unit.
// ----------------------------------------------------------------------------
package vf_pkg;

   // operation codes carried in the func field
   typedef enum logic [2:0] {
      FUNC_CROSS = 3'd0,
      FUNC_DOT   = 3'd1,
      FUNC_SUM   = 3'd2,
      FUNC_SCALE = 3'd3,
      FUNC_NORM  = 3'd4
   } func_type;

   // status codes of a result word
   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_SAT  = 2'd1,
      ST_ZERO = 2'd2
   } status_type;

   localparam int LANES      = 3;
   localparam int WORD_W     = 32;
   localparam int PROD_W     = 64;
   localparam int ACC_W      = 66;
   localparam int SQRT_STEPS = 32;

   // saturation bounds at accumulator width
   localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};

   // registered products of one lane
   typedef struct packed {
      logic signed [PROD_W-1:0] p0;
      logic signed [PROD_W-1:0] p1;
      logic signed [WORD_W:0]   sum;
   } lane_prod_type;

   // merged result of the short operations
   typedef struct packed {
      logic [LANES-1:0][WORD_W-1:0] res;
      logic [1:0]                   status;
      logic [PROD_W-1:0]            ss;
   } merge_type;

   // word carried alongside the square root and divider stages
   typedef struct packed {
      logic                         is_norm;
      logic [1:0]                   status;
      logic [LANES-1:0][WORD_W-1:0] res;
      logic [LANES-1:0][WORD_W-1:0] mag;
      logic [LANES-1:0]             neg;
   } carry_type;

   // result word
   typedef struct packed {
      logic [WORD_W-1:0] r_x;
      logic [WORD_W-1:0] r_y;
      logic [WORD_W-1:0] r_z;
      logic [1:0]        status;
   } rsp_type;

endpackage

// ===== rtl/vf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vf_req_if / vf_rsp_if
// Valid/ready channels for the operand word and the result word.
// ----------------------------------------------------------------------------
interface vf_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         func;
   logic signed [31:0] a_x;
   logic signed [31:0] a_y;
   logic signed [31:0] a_z;
   logic signed [31:0] b_x;
   logic signed [31:0] b_y;
   logic signed [31:0] b_z;
   logic signed [31:0] factor;

   modport source (output valid, func, a_x, a_y, a_z, b_x, b_y, b_z, factor,
                   input ready);
   modport sink   (input valid, func, a_x, a_y, a_z, b_x, b_y, b_z, factor,
                   output ready);
endinterface

interface vf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] r_x;
   logic signed [31:0] r_y;
   logic signed [31:0] r_z;
   logic [1:0]         status;

   modport source (output valid, r_x, r_y, r_z, status, input ready);
   modport sink   (input valid, r_x, r_y, r_z, status, output ready);
endinterface

// ===== rtl/vector3_fixed_point_alu.sv =====
`timescale 1ns / 1ps
// Every operation runs one pipeline through the 32-stage square root and then the
// (32 + FRAC_BITS)-stage dividers; FRAC_BITS = 16 gives Q16.16.
// Throughput: one word per cycle while the skid stage is empty.
// Reset clears only valid bits; req_if.ready drops only when the skid stage
// behind a stalled result word is full.
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu
// Three-lane fixed-point vector unit: cross, dot, sum, scale, normalize.
// ----------------------------------------------------------------------------
module vector3_fixed_point_alu #(
   parameter int FRAC_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   vf_req_if.sink          req_if,
   vf_rsp_if.source        rsp_if
);
   localparam int NW      = 32 + FRAC_BITS;
   localparam int CAR_LEN = vf_pkg::SQRT_STEPS + 2 + NW;
   localparam int PREP    = vf_pkg::SQRT_STEPS;

   logic adv, take;
   logic skid_vld_ff, skid_vld_in, out_vld_ff, out_vld_in;
   vf_pkg::rsp_type skid_ff, skid_in, out_ff, out_in, fin;

   assign adv           = !skid_vld_ff;
   assign take          = req_if.valid && adv;
   assign req_if.ready  = adv;

   // operand vectors, index 0 is x
   logic [2:0][31:0] vec_a, vec_b;
   assign vec_a = {req_if.a_z, req_if.a_y, req_if.a_x};
   assign vec_b = {req_if.b_z, req_if.b_y, req_if.b_x};

   // lanes: multiply stage and divider
   vf_pkg::lane_prod_type [2:0] prod;
   logic [NW-1:0] prep_num_ff [3];
   logic [31:0]   prep_m_ff;
   logic [NW-1:0] quo [3];

   for (genvar i = 0; i < vf_pkg::LANES; i++) begin : g_lane
      vf_lane #(.LANE(i), .FRAC_BITS(FRAC_BITS)) u_lane (
         .clock   (clock),
         .en      (adv),
         .func    (req_if.func),
         .vec_a   (vec_a),
         .vec_b   (vec_b),
         .factor  (req_if.factor),
         .prod    (prod[i]),
         .div_num (prep_num_ff[i]),
         .div_m   (prep_m_ff),
         .quo     (quo[i])
      );
   end

   // first stage side data
   logic             s1_vld_ff;
   logic [2:0]       s1_func_ff;
   logic [2:0][31:0] s1_mag_ff;
   logic [2:0]       s1_neg_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_func_ff <= req_if.func;
         for (int i = 0; i < vf_pkg::LANES; i++) begin
            s1_neg_ff[i] <= vec_a[i][31];
            s1_mag_ff[i] <= vec_a[i][31] ? 32'(-vec_a[i]) : vec_a[i];
         end
      end
   end

   // merge of lane products
   vf_pkg::merge_type mrg;
   vf_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
      .func (s1_func_ff),
      .prod (prod),
      .mrg  (mrg)
   );

   vf_pkg::carry_type car_in;
   vf_pkg::carry_type car_ff [CAR_LEN];
   logic              vld_ff [CAR_LEN];
   logic [63:0]       ss_ff;
   logic [31:0]       root;

   always_comb begin
      car_in.is_norm = s1_func_ff == vf_pkg::FUNC_NORM;
      car_in.res     = mrg.res;
      car_in.mag     = s1_mag_ff;
      car_in.neg     = s1_neg_ff;
      if (car_in.is_norm && s1_mag_ff == '0) car_in.status = vf_pkg::ST_ZERO;
      else                                   car_in.status = mrg.status;
   end

   // carry line alongside square root and dividers
   always_ff @(posedge clock) begin
      if (adv) begin
         ss_ff     <= mrg.ss;
         car_ff[0] <= car_in;
         for (int s = 1; s < CAR_LEN; s++) car_ff[s] <= car_ff[s-1];
         prep_m_ff <= root;
         for (int i = 0; i < vf_pkg::LANES; i++) begin
            prep_num_ff[i] <= {car_ff[PREP].mag[i], FRAC_BITS'(0)} + NW'(root >> 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         for (int s = 0; s < CAR_LEN; s++) vld_ff[s] <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= take;
         vld_ff[0] <= s1_vld_ff;
         for (int s = 1; s < CAR_LEN; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   vf_sqrt u_sqrt (
      .clock    (clock),
      .en       (adv),
      .radicand (ss_ff),
      .root     (root)
   );

   // final word: normalize results signed and clamped
   always_comb begin
      logic [2:0][31:0] res;
      logic             sat;
      vf_pkg::carry_type c;
      c   = car_ff[CAR_LEN-1];
      res = c.res;
      sat = 1'b0;
      if (c.is_norm && c.status != vf_pkg::ST_ZERO) begin
         for (int i = 0; i < vf_pkg::LANES; i++) begin
            if (c.neg[i]) begin
               if (quo[i] > NW'(32'h8000_0000)) begin
                  res[i] = 32'h8000_0000;
                  sat    = 1'b1;
               end else begin
                  res[i] = 32'(-quo[i][31:0]);
               end
            end else begin
               if (quo[i] > NW'(32'h7FFF_FFFF)) begin
                  res[i] = 32'h7FFF_FFFF;
                  sat    = 1'b1;
               end else begin
                  res[i] = quo[i][31:0];
               end
            end
         end
         fin.status = sat ? vf_pkg::ST_SAT : vf_pkg::ST_OK;
      end else begin
         fin.status = c.status;
      end
      fin.r_x = res[0];
      fin.r_y = res[1];
      fin.r_z = res[2];
   end

   // output register with skid word
   always_comb begin
      logic push;
      push        = adv && vld_ff[CAR_LEN-1];
      out_in      = out_ff;
      out_vld_in  = out_vld_ff;
      skid_in     = skid_ff;
      skid_vld_in = skid_vld_ff;
      if (!out_vld_ff || rsp_if.ready) begin
         if (skid_vld_ff) begin
            out_in      = skid_ff;
            out_vld_in  = 1'b1;
            skid_vld_in = 1'b0;
         end else begin
            out_in     = fin;
            out_vld_in = push;
         end
      end else if (push) begin
         skid_in     = fin;
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   assign rsp_if.valid  = out_vld_ff;
   assign rsp_if.r_x    = out_ff.r_x;
   assign rsp_if.r_y    = out_ff.r_y;
   assign rsp_if.r_z    = out_ff.r_z;
   assign rsp_if.status = out_ff.status;

   // skid word only exists behind a held output word
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid word without output word");

   // skid fills only when the output word stalls
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(out_vld_ff && !rsp_if.ready))
      else $error("skid filled without stall");

   // draining the output with a skid word keeps a word at the output
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && rsp_if.ready && skid_vld_ff |=> out_vld_ff)
      else $error("skid word lost");

   // zero-length normalize gives zero components
   a_zero_vec: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_ff.status == vf_pkg::ST_ZERO |->
         out_ff.r_x == '0 && out_ff.r_y == '0 && out_ff.r_z == '0)
      else $error("nonzero result on zero vector");

endmodule

// ===== rtl/vf_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vf_lane
// One vector lane: two 32x32 multipliers and a pipelined restoring divider.
// ----------------------------------------------------------------------------
module vf_lane #(
   parameter int LANE      = 0,
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [2:0]                    func,
   input  logic [2:0][31:0]              vec_a,
   input  logic [2:0][31:0]              vec_b,
   input  logic signed [31:0]            factor,
   output vf_pkg::lane_prod_type         prod,
   input  logic [32+FRAC_BITS-1:0]       div_num,
   input  logic [31:0]                   div_m,
   output logic [32+FRAC_BITS-1:0]       quo
);
   localparam int NW = 32 + FRAC_BITS;
   localparam int J  = (LANE + 1) % 3;
   localparam int K  = (LANE + 2) % 3;

   logic signed [31:0]    x0, y0, x1, y1;
   logic signed [63:0]    mul0, mul1;
   vf_pkg::lane_prod_type prod_in, prod_ff;

   // operand selection per operation
   always_comb begin
      x1 = $signed(vec_a[K]);
      y1 = $signed(vec_b[J]);
      case (func)
         vf_pkg::FUNC_CROSS: begin
            x0 = $signed(vec_a[J]);
            y0 = $signed(vec_b[K]);
         end
         vf_pkg::FUNC_SCALE: begin
            x0 = factor;
            y0 = $signed(vec_a[LANE]);
         end
         vf_pkg::FUNC_NORM: begin
            x0 = $signed(vec_a[LANE]);
            y0 = $signed(vec_a[LANE]);
         end
         default: begin
            x0 = $signed(vec_a[LANE]);
            y0 = $signed(vec_b[LANE]);
         end
      endcase
   end

   assign mul0 = x0 * y0;
   assign mul1 = x1 * y1;

   always_comb begin
      prod_in.p0  = mul0;
      prod_in.p1  = mul1;
      prod_in.sum = $signed({vec_a[LANE][31], vec_a[LANE]})
                  + $signed({vec_b[LANE][31], vec_b[LANE]});
   end

   always_ff @(posedge clock) begin
      if (en) prod_ff <= prod_in;
   end

   assign prod = prod_ff;

   // divider: one quotient bit per stage
   logic [31:0]   rem_ff [NW];
   logic [NW-1:0] num_ff [NW];
   logic [NW-1:0] quo_ff [NW];
   logic [31:0]   m_ff   [NW];
   logic [31:0]   rem_in [NW];
   logic [NW-1:0] num_in [NW];
   logic [NW-1:0] quo_in [NW];
   logic [31:0]   m_in   [NW];

   always_comb begin
      logic [31:0]   rem_src;
      logic [NW-1:0] num_src;
      logic [NW-1:0] quo_src;
      logic [31:0]   m_src;
      logic [32:0]   trial;
      logic          ge;
      for (int s = 0; s < NW; s++) begin
         if (s == 0) begin
            rem_src = '0;
            num_src = div_num;
            quo_src = '0;
            m_src   = div_m;
         end else begin
            rem_src = rem_ff[s-1];
            num_src = num_ff[s-1];
            quo_src = quo_ff[s-1];
            m_src   = m_ff[s-1];
         end
         trial     = {rem_src, num_src[NW-1]};
         ge        = trial >= {1'b0, m_src};
         rem_in[s] = ge ? 32'(trial - {1'b0, m_src}) : trial[31:0];
         num_in[s] = {num_src[NW-2:0], 1'b0};
         quo_in[s] = {quo_src[NW-2:0], ge};
         m_in[s]   = m_src;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NW; s++) begin
            rem_ff[s] <= rem_in[s];
            num_ff[s] <= num_in[s];
            quo_ff[s] <= quo_in[s];
            m_ff[s]   <= m_in[s];
         end
      end
   end

   assign quo = quo_ff[NW-1];

endmodule

// ===== rtl/vf_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vf_sqrt
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module vf_sqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] radicand,
   output logic [31:0] root
);
   localparam int STEPS = vf_pkg::SQRT_STEPS;

   logic [63:0] v_ff [STEPS];
   logic [63:0] r_ff [STEPS];
   logic [63:0] v_in [STEPS];
   logic [63:0] r_in [STEPS];

   // one trial subtract per stage
   always_comb begin
      logic [63:0] v_src, r_src, trial, bit_val;
      for (int k = 0; k < STEPS; k++) begin
         if (k == 0) begin
            v_src = radicand;
            r_src = '0;
         end else begin
            v_src = v_ff[k-1];
            r_src = r_ff[k-1];
         end
         bit_val = 64'd1 << (2 * (STEPS - 1 - k));
         trial   = r_src + bit_val;
         if (v_src >= trial) begin
            v_in[k] = v_src - trial;
            r_in[k] = (r_src >> 1) + bit_val;
         end else begin
            v_in[k] = v_src;
            r_in[k] = r_src >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < STEPS; k++) begin
            v_ff[k] <= v_in[k];
            r_ff[k] <= r_in[k];
         end
      end
   end

   assign root = r_ff[STEPS-1][31:0];

endmodule

// ===== rtl/vf_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vf_merge
// Combines lane products: cross, dot and scale with rounding, and sum, all with saturation.
// ----------------------------------------------------------------------------
module vf_merge #(
   parameter int FRAC_BITS = 16
) (
   input  logic [2:0]                    func,
   input  vf_pkg::lane_prod_type [2:0]   prod,
   output vf_pkg::merge_type             mrg
);
   localparam int AW = vf_pkg::ACC_W;
   localparam logic signed [AW-1:0] HALF = AW'(1) <<< (FRAC_BITS - 1);

   always_comb begin
      logic signed [AW-1:0] dot_acc, acc, val;
      logic                 sat;
      mrg     = '0;
      sat     = 1'b0;
      dot_acc = AW'($signed(prod[0].p0)) + AW'($signed(prod[1].p0))
              + AW'($signed(prod[2].p0));
      mrg.ss  = prod[0].p0 + prod[1].p0 + prod[2].p0;
      for (int i = 0; i < vf_pkg::LANES; i++) begin
         // exact sum at double fraction width
         case (func)
            vf_pkg::FUNC_CROSS: acc = AW'($signed(prod[i].p0)) - AW'($signed(prod[i].p1));
            vf_pkg::FUNC_DOT:   acc = (i == 0) ? dot_acc : '0;
            vf_pkg::FUNC_SCALE: acc = AW'($signed(prod[i].p0));
            default:            acc = '0;
         endcase
         if (func == vf_pkg::FUNC_SUM) val = AW'($signed(prod[i].sum));
         else                          val = (acc + HALF) >>> FRAC_BITS;
         // clamp to word range
         if (val > vf_pkg::SAT_HI) begin
            mrg.res[i] = 32'h7FFF_FFFF;
            sat        = 1'b1;
         end else if (val < vf_pkg::SAT_LO) begin
            mrg.res[i] = 32'h8000_0000;
            sat        = 1'b1;
         end else begin
            mrg.res[i] = val[31:0];
         end
      end
      mrg.status = sat ? vf_pkg::ST_SAT : vf_pkg::ST_OK;
   end

endmodule
